FILE: rtl/core/tdwc_pkg.sv
// Shared types, constants and the micro-op table of the triangle check unit.
`default_nettype none

package tdwc_pkg;

  // Stream and configuration widths
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IDX_W      = 10;
  localparam int TAG_W      = 20;

  // Vertex table depth (one entry per 10-bit index)
  localparam int VERTEX_DEPTH = 1024;

  // Multiply-accumulate: 32-bit limbs into a 256-bit two's complement sum
  localparam int LIMB_W = 32;
  localparam int ACC_W  = 256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EDGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NRM = 2'd2;

  // Register reset values
  localparam logic [31:0] MIN_EDGE_RST = 32'd1;
  localparam logic [14:0] ALIGN_RST    = 15'd1638;
  localparam logic [29:0] MIN_NRM_RST  = 30'd1;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_DEGEN  = 2'd1;
  localparam logic [1:0] STAT_CANCEL = 2'd2;
  localparam logic [1:0] STAT_WIND   = 2'd3;

  // Multiplier operands; edge, cross and normal-sum groups are in x, y, z order
  typedef enum logic [4:0] {
    OP_E1X, OP_E1Y, OP_E1Z,
    OP_E2X, OP_E2Y, OP_E2Z,
    OP_E3X, OP_E3Y, OP_E3Z,
    OP_CRX, OP_CRY, OP_CRZ,
    OP_NSX, OP_NSY, OP_NSZ,
    OP_LMAX, OP_DMAG, OP_THR, OP_TH2, OP_AREA, OP_TA, OP_NSQ
  } opnd_e;

  localparam int NUM_OPND = 22;

  // Where the sum goes when a group of products ends
  typedef enum logic [3:0] {
    DST_NONE, DST_L, DST_LMAX, DST_CRX, DST_CRY, DST_CRZ, DST_AREA,
    DST_LIM, DST_NSQ, DST_D, DST_DD, DST_TH2, DST_TA, DST_RHS
  } dst_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    logic  neg;
    dst_e  dst;
  } uop_t;

  localparam int NUM_UOPS = 29;
  localparam int STEP_W   = 5;

  // One limb product handed to the multiply-accumulate unit
  typedef struct packed {
    logic              vld;
    logic              neg;
    logic [3:0]        k;
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
  } mac_issue_t;

  // Limbs needed to hold each operand magnitude
  function automatic logic [2:0] opnd_limbs(input opnd_e op);
    logic [2:0] n;
    unique case (op)
      OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z,
      OP_E3X, OP_E3Y, OP_E3Z, OP_NSQ:           n = 3'd2;
      OP_CRX, OP_CRY, OP_CRZ, OP_LMAX, OP_DMAG: n = 3'd3;
      OP_AREA:                                  n = 3'd5;
      OP_TA:                                    n = 3'd6;
      default:                                  n = 3'd1;
    endcase
    return n;
  endfunction

  // Check sequence: edge lengths, cross, area, L*L, normals, dot, cosine terms
  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:    u = '{OP_E1X, OP_E1X, 1'b0, DST_NONE};
      5'd1:    u = '{OP_E1Y, OP_E1Y, 1'b0, DST_NONE};
      5'd2:    u = '{OP_E1Z, OP_E1Z, 1'b0, DST_L};
      5'd3:    u = '{OP_E2X, OP_E2X, 1'b0, DST_NONE};
      5'd4:    u = '{OP_E2Y, OP_E2Y, 1'b0, DST_NONE};
      5'd5:    u = '{OP_E2Z, OP_E2Z, 1'b0, DST_LMAX};
      5'd6:    u = '{OP_E3X, OP_E3X, 1'b0, DST_NONE};
      5'd7:    u = '{OP_E3Y, OP_E3Y, 1'b0, DST_NONE};
      5'd8:    u = '{OP_E3Z, OP_E3Z, 1'b0, DST_LMAX};
      5'd9:    u = '{OP_E1Y, OP_E2Z, 1'b0, DST_NONE};
      5'd10:   u = '{OP_E1Z, OP_E2Y, 1'b1, DST_CRX};
      5'd11:   u = '{OP_E1Z, OP_E2X, 1'b0, DST_NONE};
      5'd12:   u = '{OP_E1X, OP_E2Z, 1'b1, DST_CRY};
      5'd13:   u = '{OP_E1X, OP_E2Y, 1'b0, DST_NONE};
      5'd14:   u = '{OP_E1Y, OP_E2X, 1'b1, DST_CRZ};
      5'd15:   u = '{OP_CRX, OP_CRX, 1'b0, DST_NONE};
      5'd16:   u = '{OP_CRY, OP_CRY, 1'b0, DST_NONE};
      5'd17:   u = '{OP_CRZ, OP_CRZ, 1'b0, DST_AREA};
      5'd18:   u = '{OP_LMAX, OP_LMAX, 1'b0, DST_LIM};
      5'd19:   u = '{OP_NSX, OP_NSX, 1'b0, DST_NONE};
      5'd20:   u = '{OP_NSY, OP_NSY, 1'b0, DST_NONE};
      5'd21:   u = '{OP_NSZ, OP_NSZ, 1'b0, DST_NSQ};
      5'd22:   u = '{OP_CRX, OP_NSX, 1'b0, DST_NONE};
      5'd23:   u = '{OP_CRY, OP_NSY, 1'b0, DST_NONE};
      5'd24:   u = '{OP_CRZ, OP_NSZ, 1'b0, DST_D};
      5'd25:   u = '{OP_DMAG, OP_DMAG, 1'b0, DST_DD};
      5'd26:   u = '{OP_THR, OP_THR, 1'b0, DST_TH2};
      5'd27:   u = '{OP_TH2, OP_AREA, 1'b0, DST_TA};
      5'd28:   u = '{OP_TA, OP_NSQ, 1'b0, DST_RHS};
      default: u = '{OP_THR, OP_THR, 1'b0, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tdwc_mac.sv
// Limb multiply-accumulate unit: one 32x32 product per cycle into a wide signed sum.
`default_nettype none

module tdwc_mac (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tdwc_pkg::mac_issue_t         issue_i,
  input  logic                         clr_i,
  output logic [tdwc_pkg::ACC_W-1:0]   acc_o,
  output logic                         busy_o
);
  import tdwc_pkg::*;

  logic [2*LIMB_W-1:0] pp_q;
  logic                vld_q;
  logic                neg_q;
  logic [3:0]          k_q;
  logic [ACC_W-1:0]    acc_q;
  logic [ACC_W-1:0]    acc_d;
  logic [ACC_W-1:0]    pp_sh;

  // Product stage
  always_ff @(posedge clk_i) begin
    if (issue_i.vld) begin
      pp_q  <= {{LIMB_W{1'b0}}, issue_i.a} * {{LIMB_W{1'b0}}, issue_i.b};
      neg_q <= issue_i.neg;
      k_q   <= issue_i.k;
    end
  end

  // Align product to its limb position and add or subtract
  always_comb begin
    pp_sh = ACC_W'(pp_q) << {k_q, 5'd0};
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (vld_q) begin
      acc_d = neg_q ? (acc_q - pp_sh) : (acc_q + pp_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      acc_q <= '0;
    end else begin
      vld_q <= issue_i.vld;
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = vld_q;

endmodule

`default_nettype wire

FILE: rtl/core/triangle_degeneracy_winding_check_unit.sv
// Top level: vertex store, check sequencer, decision and stream ports.
`default_nettype none

// Load words (tuser 0) write one vertex into the 1024-entry position and
// normal stores in the cycle they are accepted. Check words (tuser 1) read
// the three corners from the stores (states RDA, RDB, RDC, RDW), form the
// edges, then run a fixed sequence of 135 limb products through a single
// 32x32 multiplier with a 256-bit accumulator, plus a drain and a write-back
// state for each of the 14 results it writes back, and a decision state.
// While a check runs no word is accepted; the result waits in an output
// register, so the next word is taken as soon as the check ends even if the
// result has not yet been taken. A corner never loaded since reset reads as
// whatever the store holds.
module triangle_degeneracy_winding_check_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // index_a, index_b, index_c, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
  // triangle_tag, zero fill
  input  logic [tdwc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, result_tag, zero fill
  output logic [tdwc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tdwc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tdwc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tdwc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_RDC, ST_RDW, ST_EDGE, ST_MAC, ST_DRAIN, ST_WB, ST_DEC
  } state_e;

  state_e state_q, state_d;

  // Input word fields
  logic [IDX_W-1:0] in_idx_a, in_idx_b, in_idx_c;
  logic [95:0]      in_pos;
  logic [47:0]      in_nrm;
  logic [TAG_W-1:0] in_tag;
  logic             in_acc;

  assign in_idx_a = s_axis_tdata[9:0];
  assign in_idx_b = s_axis_tdata[19:10];
  assign in_idx_c = s_axis_tdata[29:20];
  assign in_pos   = s_axis_tdata[125:30];
  assign in_nrm   = s_axis_tdata[173:126];
  assign in_tag   = s_axis_tdata[193:174];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  logic [31:0] min_edge_q;
  logic [14:0] thr_q;
  logic [29:0] min_nrm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_edge_q <= MIN_EDGE_RST;
      thr_q      <= ALIGN_RST;
      min_nrm_q  <= MIN_NRM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_EDGE: min_edge_q <= cfg_data_i;
        CFG_ALIGN:    thr_q      <= cfg_data_i[14:0];
        CFG_MIN_NRM:  min_nrm_q  <= cfg_data_i[29:0];
        default:      ;
      endcase
    end
  end

  // Vertex stores, one synchronous read port each
  logic [95:0]      pos_mem [VERTEX_DEPTH];
  logic [47:0]      nrm_mem [VERTEX_DEPTH];
  logic [95:0]      pos_rd_q;
  logic [47:0]      nrm_rd_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q;
  logic [TAG_W-1:0] tag_q;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_a_q;
    unique case (state_q)
      ST_RDA:  begin rd_en = 1'b1; rd_addr = idx_a_q; end
      ST_RDB:  begin rd_en = 1'b1; rd_addr = idx_b_q; end
      ST_RDC:  begin rd_en = 1'b1; rd_addr = idx_c_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser) begin
      pos_mem[in_idx_a] <= in_pos;
      nrm_mem[in_idx_a] <= in_nrm;
    end
    if (rd_en) begin
      pos_rd_q <= pos_mem[rd_addr];
      nrm_rd_q <= nrm_mem[rd_addr];
    end
  end

  // Corner registers: 0 = A, 1 = B, 2 = C
  logic [95:0] vpos_q [3];
  logic [47:0] vnrm_q [3];

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser) begin
      idx_a_q <= in_idx_a;
      idx_b_q <= in_idx_b;
      idx_c_q <= in_idx_c;
      tag_q   <= in_tag;
    end
    unique case (state_q)
      ST_RDB:  begin vpos_q[0] <= pos_rd_q; vnrm_q[0] <= nrm_rd_q; end
      ST_RDC:  begin vpos_q[1] <= pos_rd_q; vnrm_q[1] <= nrm_rd_q; end
      ST_RDW:  begin vpos_q[2] <= pos_rd_q; vnrm_q[2] <= nrm_rd_q; end
      default: ;
    endcase
  end

  // x - y of two signed coordinates as {sign, magnitude}
  function automatic logic [33:0] sub_sm(input logic [31:0] x, input logic [31:0] y);
    logic [33:0] d;
    logic [33:0] m;
    d = {{2{x[31]}}, x} - {{2{y[31]}}, y};
    m = d[33] ? (~d + 34'd1) : d;
    return {d[33], m[32:0]};
  endfunction

  // Edges B-A, C-A, C-B and summed normals
  logic [32:0] e_mag_d [9];
  logic        e_neg_d [9];
  logic [16:0] ns_mag_d [3];
  logic        ns_neg_d [3];

  always_comb begin
    logic [33:0] t1, t2, t3;
    logic [17:0] s, sm;
    for (int k = 0; k < 3; k++) begin
      t1 = sub_sm(vpos_q[1][32*k +: 32], vpos_q[0][32*k +: 32]);
      t2 = sub_sm(vpos_q[2][32*k +: 32], vpos_q[0][32*k +: 32]);
      t3 = sub_sm(vpos_q[2][32*k +: 32], vpos_q[1][32*k +: 32]);
      e_neg_d[k]     = t1[33];
      e_mag_d[k]     = t1[32:0];
      e_neg_d[3 + k] = t2[33];
      e_mag_d[3 + k] = t2[32:0];
      e_neg_d[6 + k] = t3[33];
      e_mag_d[6 + k] = t3[32:0];
      s = {{2{vnrm_q[0][16*k+15]}}, vnrm_q[0][16*k +: 16]}
        + {{2{vnrm_q[1][16*k+15]}}, vnrm_q[1][16*k +: 16]}
        + {{2{vnrm_q[2][16*k+15]}}, vnrm_q[2][16*k +: 16]};
      sm = s[17] ? (~s + 18'd1) : s;
      ns_neg_d[k] = s[17];
      ns_mag_d[k] = sm[16:0];
    end
  end

  // Working registers, magnitudes with separate signs
  logic [32:0]  e_mag_q [9];
  logic         e_neg_q [9];
  logic [16:0]  ns_mag_q [3];
  logic         ns_neg_q [3];
  logic [66:0]  cr_mag_q [3];
  logic         cr_neg_q [3];
  logic [65:0]  l_q;
  logic [131:0] area_q;
  logic [71:0]  lim_q;
  logic [34:0]  nsq_q;
  logic [84:0]  d_mag_q;
  logic         d_neg_q;
  logic [169:0] dd_q;
  logic [29:0]  th2_q;
  logic [161:0] ta_q;
  logic [196:0] rhs_q;

  // Operand selection
  logic [ACC_W-1:0] opnd_mag [NUM_OPND];
  logic             opnd_neg [NUM_OPND];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      opnd_mag[k] = ACC_W'(e_mag_q[k]);
      opnd_neg[k] = e_neg_q[k];
    end
    for (int k = 0; k < 3; k++) begin
      opnd_mag[9 + k]  = ACC_W'(cr_mag_q[k]);
      opnd_neg[9 + k]  = cr_neg_q[k];
      opnd_mag[12 + k] = ACC_W'(ns_mag_q[k]);
      opnd_neg[12 + k] = ns_neg_q[k];
    end
    opnd_mag[OP_LMAX] = ACC_W'(l_q);
    opnd_neg[OP_LMAX] = 1'b0;
    opnd_mag[OP_DMAG] = ACC_W'(d_mag_q);
    opnd_neg[OP_DMAG] = d_neg_q;
    opnd_mag[OP_THR]  = ACC_W'(thr_q);
    opnd_neg[OP_THR]  = 1'b0;
    opnd_mag[OP_TH2]  = ACC_W'(th2_q);
    opnd_neg[OP_TH2]  = 1'b0;
    opnd_mag[OP_AREA] = ACC_W'(area_q);
    opnd_neg[OP_AREA] = 1'b0;
    opnd_mag[OP_TA]   = ACC_W'(ta_q);
    opnd_neg[OP_TA]   = 1'b0;
    opnd_mag[OP_NSQ]  = ACC_W'(nsq_q);
    opnd_neg[OP_NSQ]  = 1'b0;
  end

  // Sequencer counters
  logic [STEP_W-1:0] step_q, step_d;
  logic [2:0]        i_q, i_d, j_q, j_d;
  uop_t              uop;
  logic [2:0]        a_limbs, b_limbs;
  logic [ACC_W-1:0]  a_mag, b_mag;
  logic              last_pp;
  mac_issue_t        issue;
  logic              mac_clr;
  logic [ACC_W-1:0]  acc;
  logic              mac_busy;

  assign uop     = uop_rom(step_q);
  assign a_limbs = opnd_limbs(uop.a);
  assign b_limbs = opnd_limbs(uop.b);
  assign a_mag   = opnd_mag[uop.a];
  assign b_mag   = opnd_mag[uop.b];
  assign last_pp = (i_q == a_limbs - 3'd1) && (j_q == b_limbs - 3'd1);

  always_comb begin
    issue.vld = (state_q == ST_MAC);
    issue.neg = opnd_neg[uop.a] ^ opnd_neg[uop.b] ^ uop.neg;
    issue.k   = {1'b0, i_q} + {1'b0, j_q};
    issue.a   = a_mag[{i_q, 5'd0} +: LIMB_W];
    issue.b   = b_mag[{j_q, 5'd0} +: LIMB_W];
  end

  assign mac_clr = (state_q == ST_WB);

  tdwc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .clr_i   (mac_clr),
    .acc_o   (acc),
    .busy_o  (mac_busy)
  );

  // Write-back value as sign and magnitude
  logic             wb_neg;
  logic [ACC_W-1:0] wb_mag;

  assign wb_neg = acc[ACC_W-1];
  assign wb_mag = wb_neg ? (~acc + ACC_W'(1)) : acc;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EDGE) begin
      for (int k = 0; k < 9; k++) begin
        e_mag_q[k] <= e_mag_d[k];
        e_neg_q[k] <= e_neg_d[k];
      end
      for (int k = 0; k < 3; k++) begin
        ns_mag_q[k] <= ns_mag_d[k];
        ns_neg_q[k] <= ns_neg_d[k];
      end
    end
    if (state_q == ST_WB) begin
      unique case (uop.dst)
        DST_L:    l_q <= wb_mag[65:0];
        DST_LMAX: if (wb_mag[65:0] > l_q) l_q <= wb_mag[65:0];
        DST_CRX:  begin cr_mag_q[0] <= wb_mag[66:0]; cr_neg_q[0] <= wb_neg; end
        DST_CRY:  begin cr_mag_q[1] <= wb_mag[66:0]; cr_neg_q[1] <= wb_neg; end
        DST_CRZ:  begin cr_mag_q[2] <= wb_mag[66:0]; cr_neg_q[2] <= wb_neg; end
        DST_AREA: area_q <= wb_mag[131:0];
        DST_LIM:  lim_q  <= wb_mag[131:60];
        DST_NSQ:  nsq_q  <= wb_mag[34:0];
        DST_D:    begin d_mag_q <= wb_mag[84:0]; d_neg_q <= wb_neg; end
        DST_DD:   dd_q   <= wb_mag[169:0];
        DST_TH2:  th2_q  <= wb_mag[29:0];
        DST_TA:   ta_q   <= wb_mag[161:0];
        DST_RHS:  rhs_q  <= wb_mag[196:0];
        default:  ;
      endcase
    end
  end

  // Decision, first failing test wins
  logic       degen, cancel, wind;
  logic [1:0] status;

  always_comb begin
    degen  = (l_q <= 66'(min_edge_q)) || (area_q <= 132'(lim_q));
    cancel = (nsq_q < 35'(min_nrm_q));
    wind   = d_neg_q || ({dd_q, 30'd0} < 200'(rhs_q));
    if (degen) begin
      status = STAT_DEGEN;
    end else if (cancel) begin
      status = STAT_CANCEL;
    end else if (wind) begin
      status = STAT_WIND;
    end else begin
      status = STAT_OK;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    i_d     = i_q;
    j_d     = j_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && s_axis_tuser) state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_RDC;
      ST_RDC:  state_d = ST_RDW;
      ST_RDW:  state_d = ST_EDGE;
      ST_EDGE: begin
        state_d = ST_MAC;
        step_d  = '0;
        i_d     = '0;
        j_d     = '0;
      end
      ST_MAC: begin
        if (last_pp) begin
          i_d = '0;
          j_d = '0;
          if (uop.dst == DST_NONE) begin
            step_d = step_q + STEP_W'(1);
          end else begin
            state_d = ST_DRAIN;
          end
        end else if (j_q == b_limbs - 3'd1) begin
          j_d = '0;
          i_d = i_q + 3'd1;
        end else begin
          j_d = j_q + 3'd1;
        end
      end
      ST_DRAIN: state_d = ST_WB;
      ST_WB: begin
        if (step_q == STEP_W'(NUM_UOPS - 1)) begin
          state_d = ST_DEC;
        end else begin
          state_d = ST_MAC;
          step_d  = step_q + STEP_W'(1);
        end
      end
      ST_DEC: if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output register
  logic             out_vld_q;
  logic [1:0]       out_stat_q;
  logic [TAG_W-1:0] out_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      i_q        <= '0;
      j_q        <= '0;
      out_vld_q  <= 1'b0;
      out_stat_q <= STAT_OK;
      out_tag_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      i_q     <= i_d;
      j_q     <= j_d;
      if (state_q == ST_DEC && state_d == ST_IDLE) begin
        out_vld_q  <= 1'b1;
        out_stat_q <= status;
        out_tag_q  <= tag_q;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_tag_q, out_stat_q};

  // Write-back only once the last product has reached the accumulator
  a_wb_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WB |-> !mac_busy)
    else $error("write-back while a product is still in flight");

  // Limb counters stay inside the current operands, the step inside the table
  a_limb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> (i_q < a_limbs) && (j_q < b_limbs) &&
                          (step_q < STEP_W'(NUM_UOPS)))
    else $error("limb or step counter out of range");

  // A finished check always presents its result
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC && state_d == ST_IDLE) |=> m_axis_tvalid)
    else $error("check finished without a result word");

endmodule

`default_nettype wire
